[hdl/ring_queue_with_peek_unit_macros.svh]
// ============================================================================
// Ring queue with peek - assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ============================================================================
`ifndef RING_QUEUE_WITH_PEEK_UNIT_MACROS_SVH
`define RING_QUEUE_WITH_PEEK_UNIT_MACROS_SVH

// Same-cycle implication: when ANTE holds, CONS must hold as well.
`define RQP_ASSERT_NOW(LBL, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ANTE) |-> (CONS)) else $error(MSG);

// Next-cycle implication: when ANTE holds, CONS must hold in the next cycle.
`define RQP_ASSERT_NEXT(LBL, ANTE, CONS, MSG) \
    LBL: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ANTE) |=> (CONS)) else $error(MSG);

`endif

[hdl/rqp_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// Ring queue with peek - package
// Field widths, action and status codes, and the control structs that pass
// between the controller and the datapath.
// ============================================================================
package rqp_pkg;

    // Default sizes of the queue.
    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 8;

    // Fixed request and response field widths.
    localparam int ACTION_W = 3;
    localparam int INDEX_W  = 4;
    localparam int DROP_W   = 8;
    localparam int STATUS_W = 2;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_ENQ    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQ    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DROP   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_PEEK   = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_MODIFY = 3'd5;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD       = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_ready;   // the request port may accept
        logic exec;         // carry out the latched request
        logic load;         // move the finished result to the output register
    } t_rqp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_valid;    // a request is offered
        logic out_free;     // the output register can take a result
    } t_rqp_sts;

endpackage

[hdl/rqp_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// Ring queue with peek - channel interfaces
// Valid/ready channels for the request and the response.
// ============================================================================

// Request channel: one queue action per request.
interface rqp_req_if
    import rqp_pkg::*;
#(
    parameter int DATA_W = DATA_W_DEF
);
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [DATA_W-1:0]   data_in;
    logic [INDEX_W-1:0]  entry_index;
    logic [DROP_W-1:0]   drop_count;

    modport source (output valid, action, data_in, entry_index, drop_count,
                    input ready);
    modport sink   (input valid, action, data_in, entry_index, drop_count,
                    output ready);
endinterface

// Response channel: one result per request.
interface rqp_rsp_if
    import rqp_pkg::*;
#(
    parameter int DATA_W = DATA_W_DEF,
    parameter int OCC_W  = $clog2(DEPTH_DEF)
);
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data_out;
    logic                is_full;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, status, data_out, is_full, occupancy,
                    input ready);
    modport sink   (input valid, status, data_out, is_full, occupancy,
                    output ready);
endinterface

[hdl/rqp_ram.sv]
`timescale 1ns / 1ps
// ============================================================================
// Ring queue with peek - generic RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
module rqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/rqp_ctrl.sv]
`timescale 1ns / 1ps
// ============================================================================
// Ring queue with peek - controller
// Sequences each request through accept, execute and result load.
// ============================================================================
module rqp_ctrl
    import rqp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rqp_sts i_sts,
    output t_rqp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and commands.
    always_comb begin
        n_state          = r_state;
        o_cmd.take_ready = 1'b0;
        o_cmd.exec       = 1'b0;
        o_cmd.load       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.take_ready = 1'b1;
                if (i_sts.req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hdl/rqp_datapath.sv]
`timescale 1ns / 1ps
// ============================================================================
// Ring queue with peek - datapath
// Request latch, ring pointers and count, storage RAM and output register.
// ============================================================================
module rqp_datapath
    import rqp_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_rqp_cmd            i_cmd,
    output t_rqp_sts            o_sts,
    input  logic                i_in_valid,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [DATA_W-1:0]   i_data_in,
    input  logic [INDEX_W-1:0]  i_entry_index,
    input  logic [DROP_W-1:0]   i_drop_count,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_data_out,
    output logic                o_is_full,
    output logic [ADDR_W-1:0]   o_occupancy
);

    localparam int CMP_A = (DROP_W > ADDR_W) ? DROP_W : ADDR_W;
    localparam int CMP_W = (INDEX_W > CMP_A) ? INDEX_W : CMP_A;
    localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST      = ADDR_W'(DEPTH - 1);

    // Latched request.
    logic [ACTION_W-1:0] r_action;
    logic [DATA_W-1:0]   r_data_in;
    logic [INDEX_W-1:0]  r_index;
    logic [DROP_W-1:0]   r_drop;

    // Queue pointers and count.
    logic [ADDR_W-1:0] r_head, n_head;
    logic [ADDR_W-1:0] r_tail, n_tail;
    logic [ADDR_W-1:0] r_fill, n_fill;

    // Result waiting for the read data.
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic                r_res_full;
    logic [ADDR_W-1:0]   r_res_occ;
    logic                r_res_rd;

    // Output register.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [DATA_W-1:0]   r_out_data;
    logic                r_out_full;
    logic [ADDR_W-1:0]   r_out_occ;

    // Storage access.
    logic              w_we, w_re;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [DATA_W-1:0] w_rdata;

    logic [CMP_W-1:0]  w_drop_x, w_fill_x, w_idx_x;
    logic [ADDR_W-1:0] w_tail_inc, w_head_inc, w_slot;

    // Ring addition; the sum stays below twice the depth.
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                   input logic [ADDR_W-1:0] off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_EXT) begin
            sum = sum - DEPTH_EXT;
        end
        return sum[ADDR_W-1:0];
    endfunction

    assign w_drop_x   = CMP_W'(r_drop);
    assign w_fill_x   = CMP_W'(r_fill);
    assign w_idx_x    = CMP_W'(r_index);
    assign w_tail_inc = (r_tail == LAST) ? '0 : r_tail + ADDR_W'(1);
    assign w_head_inc = (r_head == LAST) ? '0 : r_head + ADDR_W'(1);
    assign w_slot     = ring_add(r_head, ADDR_W'(w_idx_x) + ADDR_W'(1));

    // Decode of the latched request against the current queue state.
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_fill       = r_fill;
        n_res_status = ST_OK;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_waddr      = w_tail_inc;
        w_raddr      = w_head_inc;
        case (r_action)
            ACT_ENQ: begin
                if (r_fill != LAST) begin
                    n_tail = w_tail_inc;
                    n_fill = r_fill + ADDR_W'(1);
                    w_we   = 1'b1;
                end else begin
                    n_res_status = ST_OVERFLOW;
                end
            end
            ACT_DEQ: begin
                if (r_fill == '0) begin
                    n_res_status = ST_UNDERFLOW;
                end else begin
                    n_head = w_head_inc;
                    n_fill = r_fill - ADDR_W'(1);
                    w_re   = 1'b1;
                end
            end
            ACT_DROP: begin
                if (w_drop_x > w_fill_x) begin
                    n_head = '0;
                    n_tail = '0;
                    n_fill = '0;
                end else begin
                    n_head = ring_add(r_head, ADDR_W'(w_drop_x));
                    n_fill = r_fill - ADDR_W'(w_drop_x);
                end
            end
            ACT_CLEAR: begin
                n_head = '0;
                n_tail = '0;
                n_fill = '0;
            end
            ACT_PEEK, ACT_MODIFY: begin
                if (w_idx_x >= w_fill_x) begin
                    n_res_status = ST_BAD;
                end else if (r_action == ACT_PEEK) begin
                    w_re    = 1'b1;
                    w_raddr = w_slot;
                end else begin
                    w_we    = 1'b1;
                    w_waddr = w_slot;
                end
            end
            default: begin
                n_res_status = ST_BAD;
            end
        endcase
    end

    // Request latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_ready && i_in_valid) begin
            r_action  <= i_action;
            r_data_in <= i_data_in;
            r_index   <= i_entry_index;
            r_drop    <= i_drop_count;
        end
    end

    // Pointer and count update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else if (i_cmd.exec) begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    // Result fields that do not depend on the storage read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_status <= n_res_status;
            r_res_full   <= (n_fill == LAST);
            r_res_occ    <= n_fill;
            r_res_rd     <= w_re;
        end
    end

    // Output register: filled on load, emptied when the response is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_status <= r_res_status;
            r_out_data   <= r_res_rd ? w_rdata : '0;
            r_out_full   <= r_res_full;
            r_out_occ    <= r_res_occ;
        end
    end

    rqp_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we && i_cmd.exec),
        .i_waddr (w_waddr),
        .i_wdata (r_data_in),
        .i_re    (w_re && i_cmd.exec),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_sts.req_valid = i_in_valid;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_data_out  = r_out_data;
    assign o_is_full   = r_out_full;
    assign o_occupancy = r_out_occ;

endmodule

[hdl/ring_queue_with_peek_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// Ring queue with peek - top level
// Circular queue with one spare slot: enqueue, dequeue, drop, clear, peek
// and modify, one response per request.
// ============================================================================
//  Channel   Direction  Carries
//  i_req     in         action, data_in, entry_index, drop_count
//  o_rsp     out        status, data_out, is_full, occupancy
//
//  A request passes three states: accept latches it, execute updates the
//  pointers and addresses the storage RAM, and load moves the RAM's
//  registered read data and result into the output register when free.
//  Reset is synchronous and empties the queue; storage keeps its contents.
//  A response waiting in the output register does not block the next
//  request; a second finished result waits until the register is free.
// ============================================================================
module ring_queue_with_peek_unit
    import rqp_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rqp_req_if.sink   i_req,
    rqp_rsp_if.source o_rsp
);

    localparam int ADDR_W = $clog2(DEPTH);

    t_rqp_cmd          w_cmd;
    t_rqp_sts          w_sts;
    logic [ADDR_W-1:0] w_occupancy;

    rqp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    rqp_datapath #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_in_valid    (i_req.valid),
        .i_action      (i_req.action),
        .i_data_in     (i_req.data_in),
        .i_entry_index (i_req.entry_index),
        .i_drop_count  (i_req.drop_count),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_data_out    (o_rsp.data_out),
        .o_is_full     (o_rsp.is_full),
        .o_occupancy   (w_occupancy)
    );

    assign i_req.ready     = w_cmd.take_ready;
    assign o_rsp.occupancy = w_occupancy;

endmodule

[hdl/rqp_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// Ring queue with peek - port checker
// Checks response consistency and the output handshake at the top ports.
// ============================================================================
`include "ring_queue_with_peek_unit_macros.svh"

module rqp_checker
    import rqp_pkg::*;
#(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF,
    localparam int OCC_W = $clog2(DEPTH)
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [DATA_W-1:0]   i_data_out,
    input logic                i_is_full,
    input logic [OCC_W-1:0]    i_occupancy
);

    // A stalled response keeps its valid, status, data and occupancy.
    `RQP_ASSERT_NEXT(a_rsp_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_data_out) && $stable(i_occupancy), "stalled response changed")

    // The full flag agrees with the reported count.
    `RQP_ASSERT_NOW(a_full_count, i_out_valid, i_is_full == (i_occupancy == OCC_W'(DEPTH - 1)), "full flag disagrees with occupancy")

    // A failed request returns no data.
    `RQP_ASSERT_NOW(a_fail_zero, i_out_valid && (i_status != ST_OK), i_data_out == '0, "data returned on a failed request")

    // Overflow is reported only on a full queue, underflow only on an empty one.
    `RQP_ASSERT_NOW(a_flow_state, i_out_valid && ((i_status == ST_OVERFLOW) || (i_status == ST_UNDERFLOW)), (i_status == ST_OVERFLOW) ? i_is_full : (i_occupancy == '0), "flow status disagrees with occupancy")

endmodule

bind ring_queue_with_peek_unit rqp_checker #(
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
) u_rqp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_data_out  (o_rsp.data_out),
    .i_is_full   (o_rsp.is_full),
    .i_occupancy (o_rsp.occupancy)
);
